/* hw/rtl/ffc_pkg.sv */
// Package: format codes, stage structs and helpers for the binary32 converter.
`default_nettype none
package ffc_pkg;
	typedef enum logic [2:0] {
		FMT_F32  = 3'd0,
		FMT_F16  = 3'd1,
		FMT_BF16 = 3'd2,
		FMT_F64  = 3'd3,
		FMT_I64  = 3'd4,
		FMT_FP8  = 3'd5,
		FMT_RSV6 = 3'd6,
		FMT_RSV7 = 3'd7
	} fmt_t;

	localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;
	localparam logic [31:0] QUIET_NAN    = 32'h7FC0_0000;

	// unpacked operand: value = sig * 2^e2, or a finished pattern
	typedef struct packed {
		logic        direct;    // res already final
		logic [31:0] res;
		logic        sign;
		logic [63:0] sig;       // nonzero when not direct
		logic signed [12:0] e2;
	} unp_t;

	// normalised: sig has msb at bit 63
	typedef struct packed {
		logic        direct;
		logic [31:0] res;
		logic        sign;
		logic [63:0] sig;
		logic signed [13:0] be;  // biased exponent of msb
	} nrm_t;

	function automatic logic [5:0] lzc64(input logic [63:0] v);
		logic [5:0] n;
		logic [63:0] t;
		n = 6'd0;
		t = v;
		if (t[63:32] == 32'd0) begin n[5] = 1'b1; t = t << 32; end
		if (t[63:48] == 16'd0) begin n[4] = 1'b1; t = t << 16; end
		if (t[63:56] == 8'd0)  begin n[3] = 1'b1; t = t << 8; end
		if (t[63:60] == 4'd0)  begin n[2] = 1'b1; t = t << 4; end
		if (t[63:62] == 2'd0)  begin n[1] = 1'b1; t = t << 2; end
		if (t[63] == 1'b0)     begin n[0] = 1'b1; end
		return n;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/ffc_unpack.sv */
// Stage 1 logic: decodes the source format into sign, significand and exponent, or a finished binary32 pattern.
`default_nettype none
module ffc_unpack
	import ffc_pkg::*;
(
	input  wire  fmt_t        fmt,
	input  wire  logic [63:0] x,
	output unp_t              u
);
	logic        hs, fs, ds;
	logic [4:0]  he;
	logic [9:0]  hm;
	logic [3:0]  fe;
	logic [2:0]  fm;
	logic [10:0] de;
	logic [51:0] dm;
	logic [63:0] mag;

	always_comb begin
		hs = x[15]; he = x[14:10]; hm = x[9:0];
		fs = x[7];  fe = x[6:3];   fm = x[2:0];
		ds = x[63]; de = x[62:52]; dm = x[51:0];
		mag = x[63] ? (64'd0 - x) : x;
		u.direct = 1'b1;
		u.res = 32'd0;
		u.sign = 1'b0;
		u.sig = 64'd1;
		u.e2 = 13'sd0;
		unique case (fmt)
			FMT_F32: u.res = x[31:0];
			FMT_BF16: u.res = {x[15:0], 16'd0};
			FMT_F16: begin
				if (he == 5'd0) begin
					if (hm == 10'd0) u.res = {hs, 31'd0};
					else begin
						u.direct = 1'b0; u.sign = hs;
						u.sig = {54'd0, hm}; u.e2 = -13'sd24;
					end
				end else if (he == 5'h1F)
					u.res = {hs, 31'd0} | EXP_ALL_ONES | {9'd0, hm, 13'd0};
				else
					u.res = {hs, 8'(he) + 8'd112, hm, 13'd0};
			end
			FMT_FP8: begin
				if (fe == 4'd0) begin
					if (fm == 3'd0) u.res = {fs, 31'd0};
					else begin
						u.direct = 1'b0; u.sign = fs;
						u.sig = {61'd0, fm}; u.e2 = -13'sd9;
					end
				end else if (fe == 4'hF && fm == 3'd7)
					u.res = {fs, 31'd0} | QUIET_NAN;
				else
					u.res = {fs, 8'(fe) + 8'd120, fm, 20'd0};
			end
			FMT_F64: begin
				if (de == 11'h7FF) begin
					if (dm == 52'd0) u.res = {ds, 31'd0} | EXP_ALL_ONES;
					else u.res = {ds, 31'd0} | QUIET_NAN | {10'd0, dm[51:30]};
				end else if (de == 11'd0) begin
					if (dm == 52'd0) u.res = {ds, 31'd0};
					else begin
						u.direct = 1'b0; u.sign = ds;
						u.sig = {12'd0, dm}; u.e2 = -13'sd1074;
					end
				end else begin
					u.direct = 1'b0; u.sign = ds;
					u.sig = {11'd0, 1'b1, dm};
					u.e2 = $signed({2'b00, de}) - 13'sd1075;
				end
			end
			FMT_I64: begin
				if (x != 64'd0) begin
					u.direct = 1'b0; u.sign = x[63];
					u.sig = mag; u.e2 = 13'sd0;
				end
			end
			default: u.res = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

/* hw/rtl/ffc_round.sv */
// Stage 3 logic: denormalising shift, round to nearest even and packing.
`default_nettype none
module ffc_round
	import ffc_pkg::*;
(
	input  wire  nrm_t        n,
	output logic [31:0]       res
);
	logic signed [13:0] eb;
	logic [13:0]        extra;
	logic [6:0]         dsh;
	logic [63:0]        t;
	logic               sticky;
	logic [23:0]        q;
	logic [24:0]        r;
	logic               g, st;
	logic [32:0]        bits;

	always_comb begin
		eb = (n.be >= 14'sd1) ? n.be : 14'sd1;
		extra = 14'(eb - n.be);
		dsh = (extra > 14'd64) ? 7'd64 : extra[6:0];
		// shift right by dsh keeping sticky
		if (dsh >= 7'd64) begin
			t = 64'd0; sticky = n.sig != 64'd0;
		end else begin
			t = n.sig >> dsh[5:0];
			sticky = (n.sig & ((64'd1 << dsh[5:0]) - 64'd1)) != 64'd0;
		end
		q = t[63:40];
		g = t[39];
		st = sticky || (t[38:0] != 39'd0);
		r = {1'b0, q} + 25'((g && (st || q[0])) ? 1 : 0);
		bits = {19'd0, 14'(eb - 14'sd1)} << 23;
		bits = bits + {8'd0, r};
		if (n.direct) res = n.res;
		else if (n.be >= 14'sd255 || bits >= 33'(EXP_ALL_ONES))
			res = {n.sign, 31'd0} | EXP_ALL_ONES;
		else res = {n.sign, bits[30:0]};
	end
endmodule
`default_nettype wire

/* hw/rtl/float_format_to_fp32_converter.sv */
// Top level: three stage pipelined element format to binary32 converter.
// One word may enter every cycle while the output is not stalled: stage one
// decodes the format, stage two counts leading zeros and normalises, stage
// three rounds and packs. A stall on the output while a result waits holds
// the full pipeline; fmt_q, written by cfg_we, is applied as a word enters.
`default_nettype none
module float_format_to_fp32_converter
	import ffc_pkg::*;
(
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        cfg_we,
	input  wire  logic [2:0]  cfg_wdata,
	input  wire  logic        in_valid,
	output logic              in_stall,
	input  wire  logic [63:0] raw_element,
	output logic              out_valid,
	input  wire  logic        out_stall,
	output logic [31:0]       fp32_bits
);
	logic [2:0] fmt_q;
	logic       v_s1, v_s2, v_s3;
	unp_t       u, u_s1;
	nrm_t       n, n_s2;
	logic [31:0] r, r_s3;
	logic [5:0]  lz;
	logic        adv;

	assign adv = !(v_s3 && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s3;
	assign fp32_bits = r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= 3'd0;
		else if (cfg_we) fmt_q <= cfg_wdata;
	end

	ffc_unpack u_unp (.fmt(fmt_t'(fmt_q)), .x(raw_element), .u(u));

	always_comb begin
		lz = lzc64(u_s1.sig);
		n.direct = u_s1.direct;
		n.res = u_s1.res;
		n.sign = u_s1.sign;
		n.sig = u_s1.sig << lz;
		n.be = 14'(u_s1.e2) + 14'sd190 - 14'(lz);
	end

	ffc_round u_rnd (.n(n_s2), .res(r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= u; n_s2 <= n; r_s3 <= r;
		end
	end
endmodule
`default_nettype wire

/* sim/float_format_to_fp32_converter_test.sv */
// Testbench: element format to binary32 converter, checked against an in-bench predictor.
`timescale 1ns / 1ps
module float_format_to_fp32_converter_test
	import ffc_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] raw_element;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] fp32_bits;

	fmt_t        cur_fmt;
	logic [31:0] expected_bits[$];
	int          fail_count;
	int          words_sent;
	int          words_checked;
	int          idle_cycles;
	bit          sender_idles;
	bit          receiver_idles;
	bit          long_hold;

	float_format_to_fp32_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_element(raw_element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fp32_bits(fp32_bits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int msb_index(input logic [63:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (v[i])
				p = i;
		return p;
	endfunction

	// sign and sig * 2^e2 rounded to nearest even into binary32
	function automatic logic [31:0] round_pack(input logic s, input logic [63:0] sig,
			input int e2);
		int p;
		int be;
		int eb;
		int sh;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] bits;
		p = msb_index(sig);
		be = p + e2 + 127;
		if (be >= 255)
			return {s, 31'h7F80_0000};
		eb = (be >= 1) ? be : 1;
		sh = p - 23 + (eb - be);
		if (sh <= 0)
			q = sig << (-sh);
		else if (sh >= 64)
			q = 64'd0;
		else begin
			q = sig >> sh;
			rem = sig & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
		end
		bits = (64'(eb - 1) << 23) + q;
		if (bits >= 64'h7F80_0000)
			bits = 64'h7F80_0000;
		return {s, bits[30:0]};
	endfunction

	function automatic logic [31:0] convert_element(input fmt_t f, input logic [63:0] x);
		logic [63:0] mag;
		case (f)
			FMT_F32: return x[31:0];
			FMT_BF16: return {x[15:0], 16'd0};
			FMT_F16: begin
				if (x[14:10] == 5'd0)
					return (x[9:0] == 10'd0) ? {x[15], 31'd0}
						: round_pack(x[15], {54'd0, x[9:0]}, -24);
				if (x[14:10] == 5'h1F)
					return {x[15], 8'hFF, x[9:0], 13'd0};
				return {x[15], 8'(x[14:10] + 8'd112), x[9:0], 13'd0};
			end
			FMT_FP8: begin
				if (x[6:3] == 4'd0)
					return (x[2:0] == 3'd0) ? {x[7], 31'd0}
						: round_pack(x[7], {61'd0, x[2:0]}, -9);
				if (x[6:3] == 4'hF && x[2:0] == 3'd7)
					return {x[7], 31'h7FC0_0000};
				return {x[7], 8'(x[6:3] + 8'd120), x[2:0], 20'd0};
			end
			FMT_F64: begin
				if (x[62:52] == 11'h7FF)
					return (x[51:0] == 52'd0) ? {x[63], 31'h7F80_0000}
						: ({x[63], 31'h7FC0_0000} | {10'd0, x[51:30]});
				if (x[62:52] == 11'd0)
					return (x[51:0] == 52'd0) ? {x[63], 31'd0}
						: round_pack(x[63], {12'd0, x[51:0]}, -1074);
				return round_pack(x[63], {12'd1, x[51:0]}, int'(x[62:52]) - 1075);
			end
			FMT_I64: begin
				mag = x[63] ? (64'd0 - x) : x;
				if (mag == 64'd0)
					return 32'd0;
				return round_pack(x[63], mag, 0);
			end
			default: return 32'd0;
		endcase
	endfunction

	task automatic send_word(input logic [63:0] w);
		while (sender_idles && ($urandom_range(99) < 28)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_element <= w;
		expected_bits.push_back(convert_element(cur_fmt, w));
		words_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_bits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_format(input fmt_t f);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = f;
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// random words, partly shaped toward edge cases and exponent ranges for F64, I64, F16 and FP8
	function automatic logic [63:0] shaped_word(input fmt_t f);
		logic [63:0] w;
		w = random_word();
		case (f)
			FMT_F64: begin
				case ($urandom_range(5))
					0: w[62:52] = 11'(1023 + $urandom_range(127) - 63);
					1: w[62:52] = 11'(1023 - 126 - $urandom_range(30));
					2: w[62:52] = 11'(1023 + 126 + $urandom_range(3));
					3: w[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
					4: w[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'd0;
					default: ;
				endcase
			end
			FMT_I64: begin
				case ($urandom_range(3))
					0: w = w >> $urandom_range(63);
					1: w = -(w >> $urandom_range(63));
					2: w = w & ~64'(($urandom_range(1) ? 64'hFF : 64'hFFFF_FFFF));
					default: ;
				endcase
			end
			FMT_F16: if ($urandom_range(3) == 0)
				w[14:10] = $urandom_range(1) ? 5'h1F : 5'd0;
			FMT_FP8: if ($urandom_range(3) == 0)
				w[6:3] = $urandom_range(1) ? 4'hF : 4'd0;
			default: ;
		endcase
		return w;
	endfunction

	task automatic test_directed_edges();
		set_format(FMT_F32);
		send_word(64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'd0);
		set_format(FMT_F16);
		send_word(64'hFFFF_FFFF_FFFF_0001);
		send_word(64'h0000_0000_0000_83FF);
		send_word(64'h0000_0000_0000_7C00);
		send_word(64'h0000_0000_0000_FE01);
		send_word(64'h0000_0000_0000_3C00);
		set_format(FMT_BF16);
		send_word(64'hAAAA_5555_1234_FFFF);
		set_format(FMT_FP8);
		send_word(64'hFFFF_FFFF_FFFF_FF7F);
		send_word(64'h0000_0000_0000_0077);
		send_word(64'h0000_0000_0000_0081);
		send_word(64'h0000_0000_0000_0007);
		send_word(64'h0000_0000_0000_0080);
		set_format(FMT_F64);
		send_word(64'h7FF0_0000_0000_0000);
		send_word(64'hFFF8_0000_DEAD_BEEF);
		send_word(64'h47F0_0000_0000_0000);
		send_word(64'h8000_0000_0000_0000);
		send_word(64'h0000_0000_0000_0001);
		send_word(64'h36A0_0000_0000_0001);
		send_word(64'h3FF0_0000_1000_0000);
		set_format(FMT_I64);
		send_word(64'd0);
		send_word(64'h8000_0000_0000_0000);
		send_word(64'h7FFF_FFFF_FFFF_FFFF);
		send_word(64'hFFFF_FFFF_FFFF_FFFF);
		set_format(FMT_RSV7);
		send_word(64'h3FF0_0000_0000_0000);
	endtask

	task automatic test_random_formats();
		fmt_t f;
		for (int phase = 0; phase < 14; phase++) begin
			f = fmt_t'(phase < 6 ? phase : $urandom_range(7));
			set_format(f);
			for (int i = 0; i < 45; i++)
				send_word(f == FMT_F32 && i < 4 ? random_word() : shaped_word(f));
		end
	endtask

	task automatic test_back_pressure();
		set_format(FMT_F64);
		long_hold = 1'b1;
		for (int i = 0; i < 20; i++)
			send_word(shaped_word(FMT_F64));
		drain_results();
		// sender pauses until everything is back
		set_format(FMT_I64);
		for (int i = 0; i < 10; i++)
			send_word(shaped_word(FMT_I64));
	endtask

	task automatic test_no_idling();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		set_format(FMT_F16);
		for (int i = 0; i < 60; i++)
			send_word(shaped_word(FMT_F16));
		set_format(FMT_FP8);
		for (int i = 0; i < 40; i++)
			send_word(random_word());
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 3'd0;
		in_valid = 1'b0;
		raw_element = 64'd0;
		cur_fmt = FMT_F32;
		fail_count = 0;
		words_sent = 0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		long_hold = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_formats();
		test_back_pressure();
		test_no_idling();
		drain_results();
		$display("Sent %0d words over the six source formats and undefined codes, checked %0d,",
			words_sent, words_checked);
		$display("with random idling, a long output hold and an unthrottled stretch.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// receiver stall, with one long hold-off counted here
	initial begin
		int hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold && hold == 0) begin
				hold = 1;
				out_stall <= 1'b1;
				repeat (40) @(posedge clk);
				long_hold = 1'b0;
			end
			out_stall <= receiver_idles && ($urandom_range(99) < 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (expected_bits.size() == 0) begin
				$error("fp32_bits: unexpected word %h", fp32_bits);
				fail_count++;
			end else begin
				if (fp32_bits !== expected_bits[0]) begin
					$error("fp32_bits: expected %h actual %h", expected_bits[0], fp32_bits);
					fail_count++;
				end
				void'(expected_bits.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial idle_cycles = 0;
	initial words_checked = 0;
endmodule
